### design/rle_enc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run-length encoder package
// Shared types, constants and a helper function of the run-length encoder.
// ----------------------------------------------------------------------------
package rle_enc_pkg;

   localparam int ByteWidth = 8;
   localparam int CountWidth = 4;
   localparam logic [CountWidth-1:0] RunLimit = 4'd9;
   localparam logic [CountWidth-1:0] MaxRunReset = 4'd9;
   localparam logic [ByteWidth-1:0] DigitZero = 8'h30;

   localparam int QueueDepth = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [ByteWidth-1:0]  run_byte;
      logic [CountWidth-1:0] run_count;
      logic                  last;
   } pair_type;

   typedef struct packed {
      logic     valid_a;
      logic     valid_b;
      pair_type pair_a;
      pair_type pair_b;
   } push_type;

   function automatic logic [CountWidth-1:0] eff_max(input logic [CountWidth-1:0] m);
      logic [CountWidth-1:0] r;
      if (m == '0) begin
         r = {{(CountWidth-1){1'b0}}, 1'b1};
      end else if (m > RunLimit) begin
         r = RunLimit;
      end else begin
         r = m;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### design/rle_enc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run-length encoder channel interfaces
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------
interface rle_enc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface rle_enc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

interface rle_enc_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] max_run;
   modport source (output valid, output max_run, input ready);
   modport sink (input valid, input max_run, output ready);
endinterface
`default_nettype wire

### design/rle_enc_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run-length encoder run tracker
// Registers each request, extends or closes the open run and pushes the
// closed and flushed runs to the pair queue.
// ----------------------------------------------------------------------------
module rle_enc_tracker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rle_enc_req_if.sink                              req,
   input  wire logic [rle_enc_pkg::CountWidth-1:0]  max_run,
   input  wire logic                                space_ok,
   output      rle_enc_pkg::push_type               push
);
   import rle_enc_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  in_last_ff;
   logic [ByteWidth-1:0]  run_byte_ff, run_byte_in;
   logic [CountWidth-1:0] run_count_ff, run_count_in;
   logic                  run_open_ff, run_open_in;
   logic                  advance;
   logic                  req_take;

   assign advance  = in_valid_ff && space_ok;
   assign req.ready = !in_valid_ff || advance;
   assign req_take = req.valid && req.ready;

   always_comb begin
      logic [ByteWidth-1:0]  nb;
      logic [CountWidth-1:0] nc;
      logic                  close;
      nb    = run_byte_ff;
      nc    = run_count_ff;
      close = 1'b0;
      if (!run_open_ff) begin
         nb = in_byte_ff;
         nc = {{(CountWidth-1){1'b0}}, 1'b1};
      end else if (in_byte_ff == run_byte_ff && run_count_ff < eff_max(max_run)) begin
         nc = run_count_ff + 1'b1;
      end else begin
         close = 1'b1;
         nb    = in_byte_ff;
         nc    = {{(CountWidth-1){1'b0}}, 1'b1};
      end

      push = '0;
      if (close) begin
         push.valid_a = advance;
         push.pair_a  = '{run_byte: run_byte_ff, run_count: run_count_ff, last: 1'b0};
         push.valid_b = advance && in_last_ff;
         push.pair_b  = '{run_byte: nb, run_count: nc, last: 1'b1};
      end else begin
         push.valid_a = advance && in_last_ff;
         push.pair_a  = '{run_byte: nb, run_count: nc, last: 1'b1};
      end

      run_byte_in  = run_byte_ff;
      run_count_in = run_count_ff;
      run_open_in  = run_open_ff;
      if (advance) begin
         if (in_last_ff) begin
            run_byte_in  = '0;
            run_count_in = '0;
            run_open_in  = 1'b0;
         end else begin
            run_byte_in  = nb;
            run_count_in = nc;
            run_open_in  = 1'b1;
         end
      end

      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         run_byte_ff  <= '0;
         run_count_ff <= '0;
         run_open_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         run_byte_ff  <= run_byte_in;
         run_count_ff <= run_count_in;
         run_open_ff  <= run_open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req.in_byte;
         in_last_ff <= req.in_last;
      end
   end

   // An open run always holds a count of one up to the run limit.
   a_open_count: assert property (@(posedge clock) disable iff (reset)
      run_open_ff |-> (run_count_ff != '0 && run_count_ff <= RunLimit))
      else $error("open run count out of range");

   // A final request leaves no open run behind.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (!run_open_ff && run_count_ff == '0))
      else $error("run still open after final request");

endmodule
`default_nettype wire

### design/rle_enc_pair_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run-length encoder pair queue
// Holds closed runs and sends each as the run byte followed by its digit.
// ----------------------------------------------------------------------------
module rle_enc_pair_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rle_enc_pkg::push_type push,
   output logic                       space_ok,
   rle_enc_rsp_if.source              rsp
);
   import rle_enc_pkg::*;

   pair_type                 entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;
   logic                     phase_ff, phase_in;
   logic                     rsp_take;
   logic                     pop;
   logic [QueuePtrWidth-1:0] wr_ptr_b;
   pair_type                 head;

   assign space_ok = count_ff <= QueueCntWidth'(QueueDepth - 2);
   assign head     = entry_ff[rd_ptr_ff];
   assign wr_ptr_b = wr_ptr_ff + 1'b1;

   assign rsp.valid    = count_ff != '0;
   assign rsp.out_byte = phase_ff ? DigitZero + ByteWidth'(head.run_count) : head.run_byte;
   assign rsp.out_last = phase_ff && head.last;

   assign rsp_take = rsp.valid && rsp.ready;
   assign pop      = rsp_take && phase_ff;

   always_comb begin
      logic [QueueCntWidth-1:0] npush;
      npush     = QueueCntWidth'(push.valid_a) + QueueCntWidth'(push.valid_b);
      count_in  = count_ff + npush - QueueCntWidth'(pop);
      wr_ptr_in = wr_ptr_ff + QueuePtrWidth'(npush);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      phase_in  = rsp_take ? !phase_ff : phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         phase_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid_a) begin
         entry_ff[wr_ptr_ff] <= push.pair_a;
      end
      if (push.valid_b) begin
         entry_ff[wr_ptr_b] <= push.pair_b;
      end
   end

   // Pushes arrive only when two free entries are available.
   a_push_space: assert property (@(posedge clock) disable iff (reset)
      (push.valid_a || push.valid_b) |-> space_ok)
      else $error("pair pushed into a full queue");

   // A second pair is never pushed without a first one.
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.valid_b |-> push.valid_a)
      else $error("second pair pushed alone");

   // A run byte that is taken is followed by its digit from the same entry.
   a_digit_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !phase_ff) |=> (phase_ff && rsp.valid && $stable(rd_ptr_ff)))
      else $error("digit does not follow its run byte");

endmodule
`default_nettype wire

### design/rle_digit_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run-length digit encoder
// Encodes a byte stream as run byte and ASCII count digit pairs.
// ----------------------------------------------------------------------------
// The run byte of a closed run passes the input register and the pair queue before
// it is offered, and its digit follows in the cycle after the run byte is taken.
// The unit takes one request per cycle while runs stay open and the pair queue has
// space; each closed run is sent as two results, so the result port sets the rate.
// Reset clears the run state and the pair queue and sets max_run to nine.
module rle_digit_encoder_unit (
   input wire logic      clock,
   input wire logic      reset,
   rle_enc_req_if.sink   req_chan,
   rle_enc_rsp_if.source rsp_chan,
   rle_enc_csr_if.sink   csr_chan
);
   import rle_enc_pkg::*;

   logic [CountWidth-1:0] max_run_ff;
   push_type              push;
   logic                  space_ok;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_run_ff <= MaxRunReset;
      end else if (csr_chan.valid && csr_chan.ready) begin
         max_run_ff <= csr_chan.max_run;
      end
   end

   rle_enc_tracker u_tracker (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .max_run  (max_run_ff),
      .space_ok (space_ok),
      .push     (push)
   );

   rle_enc_pair_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp      (rsp_chan)
   );

endmodule
`default_nettype wire
